// File: hw/rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types for the LCS length unit: command and result beats, item kinds
// and the control token that travels down the cell chain.
// ----------------------------------------------------------------------------
package lcs_pkg;

	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_PROCESS = 2'd1,
		KIND_FINISH  = 2'd2
	} kind_t;

	localparam int SymW = 8;
	localparam int LenW = 7;

	typedef struct packed {
		logic [1:0]      kind;
		logic [SymW-1:0] symbol;
	} lcs_in_t;

	typedef struct packed {
		logic [LenW-1:0] lcs_length;
		logic            overflow;
	} lcs_out_t;

	// token handed from cell to cell each cycle
	typedef struct packed {
		logic            valid;
		logic            fin;
		logic            ovf;
		logic [SymW-1:0] sym;
	} lcs_tok_t;

endpackage

// File: hw/rtl/lcs_cell.sv
// ----------------------------------------------------------------------------
// lcs_cell
// One y cell of the systolic chain: holds one y symbol and its row value,
// updates the value when an x token passes and forwards token, new value
// and old value to the next cell.
// ----------------------------------------------------------------------------
module lcs_cell #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load_en,
	input  logic [CW-1:0]             load_idx,
	input  logic [lcs_pkg::SymW-1:0]  load_sym,
	input  lcs_pkg::lcs_tok_t         tok_i,
	input  logic [CW-1:0]             lim_i,
	input  logic [CW-1:0]             len_i,
	input  logic [CW-1:0]             left_i,
	input  logic [CW-1:0]             diag_i,
	output lcs_pkg::lcs_tok_t         tok_o,
	output logic [CW-1:0]             lim_o,
	output logic [CW-1:0]             len_o,
	output logic [CW-1:0]             left_o,
	output logic [CW-1:0]             diag_o
);

	logic [lcs_pkg::SymW-1:0] y_q;
	logic [CW-1:0]            dp_q;
	lcs_pkg::lcs_tok_t        tok_q;
	logic [CW-1:0]            lim_q;
	logic [CW-1:0]            len_q;
	logic [CW-1:0]            left_q;
	logic [CW-1:0]            diag_q;

	logic          active;
	logic          last;
	logic [CW-1:0] cell_val;

	always_comb begin
		// a token only touches cells that were loaded before it was issued
		active   = tok_i.valid && (CW'(IDX) < lim_i);
		last     = tok_i.valid && tok_i.fin && (CW'(IDX + 1) == lim_i);
		if (y_q == tok_i.sym) begin
			cell_val = diag_i + CW'(1);
		end else begin
			cell_val = (left_i > dp_q) ? left_i : dp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q  <= '0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_i;
			if (active) begin
				// finish clears the row behind it
				dp_q <= tok_i.fin ? '0 : cell_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && (load_idx == CW'(IDX))) begin
			y_q <= load_sym;
		end
		lim_q  <= lim_i;
		left_q <= cell_val;
		diag_q <= dp_q;
		len_q  <= last ? dp_q : len_i;
	end

	assign tok_o  = tok_q;
	assign lim_o  = lim_q;
	assign len_o  = len_q;
	assign left_o = left_q;
	assign diag_o = diag_q;

endmodule

// File: hw/rtl/lcs_length_unit.sv
// ----------------------------------------------------------------------------
// lcs_length_unit
// Length of the longest common subsequence of two byte strings, computed by
// a chain of MAX_LEN y cells through which x symbols ripple one cell a cycle.
//
//   channel   ports                     handshake
//   command   cmd (kind, symbol)        start, busy   taken at start && !busy
//   result    result (length, overflow) done          one-cycle strobe
//
// Load and process beats are taken every cycle while busy is low; x tokens
// overlap in the chain as a diagonal wavefront. A finish beat raises busy;
// its token walks the whole chain and the result strobes in the same cycle
// that busy drops. Reset clears every row value at once; no clearing pass.
// The receiver cannot stall, so nothing holds the chain.
// ----------------------------------------------------------------------------
module lcs_length_unit #(
	parameter int MAX_LEN = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  lcs_pkg::lcs_in_t cmd,
	output logic             done,
	output lcs_pkg::lcs_out_t result
);

	localparam int CW = $clog2(MAX_LEN + 1);

	logic [CW-1:0]     count_q;
	logic              dropped_q;
	logic              busy_q;
	logic              done_q;
	lcs_pkg::lcs_out_t result_q;
	lcs_pkg::lcs_tok_t tok_q;
	logic [CW-1:0]     lim_q;

	lcs_pkg::lcs_tok_t tok  [0:MAX_LEN];
	logic [CW-1:0]     lim  [0:MAX_LEN];
	logic [CW-1:0]     len  [0:MAX_LEN];
	logic [CW-1:0]     left [0:MAX_LEN];
	logic [CW-1:0]     diag [0:MAX_LEN];

	logic accept;
	logic is_load;
	logic is_proc;
	logic is_fin;
	logic full;
	logic load_en;

	always_comb begin
		accept  = start && !busy_q;
		is_load = cmd.kind == lcs_pkg::KIND_LOAD;
		is_proc = cmd.kind == lcs_pkg::KIND_PROCESS;
		is_fin  = cmd.kind == lcs_pkg::KIND_FINISH;
		full    = count_q == CW'(MAX_LEN);
		load_en = accept && is_load && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			tok_q     <= '0;
		end else begin
			tok_q.valid <= accept && (is_proc || is_fin);
			tok_q.fin   <= is_fin;
			tok_q.ovf   <= dropped_q;
			tok_q.sym   <= cmd.symbol;
			if (load_en) begin
				count_q <= count_q + CW'(1);
			end
			if (accept && is_load && full) begin
				dropped_q <= 1'b1;
			end
			if (accept && is_fin) begin
				// the token carries the flag and lim_q the limit; state is free again
				count_q   <= '0;
				dropped_q <= 1'b0;
				busy_q    <= 1'b1;
			end
			done_q <= tok[MAX_LEN].valid && tok[MAX_LEN].fin;
			if (tok[MAX_LEN].valid && tok[MAX_LEN].fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lim_q <= count_q;
		if (tok[MAX_LEN].valid && tok[MAX_LEN].fin) begin
			result_q.lcs_length <= lcs_pkg::LenW'(len[MAX_LEN]);
			result_q.overflow   <= tok[MAX_LEN].ovf;
		end
	end

	assign tok[0]  = tok_q;
	assign lim[0]  = lim_q;
	assign len[0]  = '0;
	assign left[0] = '0;
	assign diag[0] = '0;

	for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
		lcs_cell #(
			.CW  (CW),
			.IDX (j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load_en  (load_en),
			.load_idx (count_q),
			.load_sym (cmd.symbol),
			.tok_i    (tok[j]),
			.lim_i    (lim[j]),
			.len_i    (len[j]),
			.left_i   (left[j]),
			.diag_i   (diag[j]),
			.tok_o    (tok[j+1]),
			.lim_o    (lim[j+1]),
			.len_o    (len[j+1]),
			.left_o   (left[j+1]),
			.diag_o   (diag[j+1])
		);
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule

// File: hw/rtl/lcs_chk.sv
// ----------------------------------------------------------------------------
// lcs_chk
// Port-level checks for the LCS length unit, bound to the top level.
// ----------------------------------------------------------------------------
module lcs_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input lcs_pkg::lcs_in_t  cmd,
	input logic              done,
	input lcs_pkg::lcs_out_t result
);

	// a finish beat holds off further commands
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.kind == lcs_pkg::KIND_FINISH) |=> busy)
		else $error("busy not raised after finish beat");

	// other beats never stall the port
	a_other_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.kind != lcs_pkg::KIND_FINISH) |=> !busy)
		else $error("busy raised by a non-finish beat");

	// busy drops exactly with the result strobe
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && !$isunknown(result))
		else $error("result strobed while busy or with unknown bits");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind lcs_length_unit lcs_chk u_lcs_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

// File: sim/lcs_length_unit_test.sv
// ----------------------------------------------------------------------------
// lcs_length_unit_test
// Streams y loads, x symbols and finish beats into the LCS length unit. A
// predictor in the testbench tracks the y store and the DP row and works out
// each finish result. The checker compares every result strobe against the
// oldest expected result, field by field.
// ----------------------------------------------------------------------------
module lcs_length_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 64;
	localparam int IDLE_LIMIT = 1000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	lcs_pkg::lcs_in_t  cmd = '0;
	logic              busy;
	logic              done;
	lcs_pkg::lcs_out_t result;

	lcs_length_unit #(.MAX_LEN(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted state of the unit
	logic [lcs_pkg::SymW-1:0] y_syms [CAPACITY];
	int                       y_len = 0;
	logic [lcs_pkg::LenW-1:0] row_len [CAPACITY];
	logic                     y_dropped = 1'b0;

	lcs_pkg::lcs_out_t pending_lengths [$];
	int                mismatches = 0;
	int                items_sent = 0;
	int                gap_pct = 0;
	int                idle_cycles = 0;

	task automatic flag_mismatch(string what, int got, int want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic clear_model();
		for (int j = 0; j < CAPACITY; j++) begin
			y_syms[j] = '0;
			row_len[j] = '0;
		end
		y_len = 0;
		y_dropped = 1'b0;
	endtask

	// sweep one x symbol across the stored y symbols
	task automatic advance_row(logic [lcs_pkg::SymW-1:0] x_sym);
		logic [lcs_pkg::LenW-1:0] diag;
		logic [lcs_pkg::LenW-1:0] left;
		logic [lcs_pkg::LenW-1:0] up;
		logic [lcs_pkg::LenW-1:0] nxt;
		diag = '0;
		left = '0;
		for (int j = 0; j < y_len; j++) begin
			up = row_len[j];
			if (y_syms[j] == x_sym)
				nxt = diag + 1'b1;
			else
				nxt = (left > up) ? left : up;
			diag = up;
			row_len[j] = nxt;
			left = nxt;
		end
	endtask

	task automatic predict_beat(lcs_pkg::lcs_in_t beat);
		lcs_pkg::lcs_out_t want;
		case (beat.kind)
			lcs_pkg::KIND_LOAD: begin
				if (y_len < CAPACITY) begin
					y_syms[y_len] = beat.symbol;
					row_len[y_len] = '0;
					y_len++;
				end else begin
					y_dropped = 1'b1;
				end
			end
			lcs_pkg::KIND_PROCESS: begin
				advance_row(beat.symbol);
			end
			lcs_pkg::KIND_FINISH: begin
				want.lcs_length = (y_len > 0) ? row_len[y_len-1] : '0;
				want.overflow = y_dropped;
				pending_lengths.push_back(want);
				clear_model();
			end
			default: begin
				// unused kind: no effect
			end
		endcase
	endtask

	// check strobes first: a beat taken in the same cycle yields a later result
	always @(posedge clk) begin
		lcs_pkg::lcs_out_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_lengths.size() == 0) begin
					flag_mismatch("unexpected result", result.lcs_length, -1);
				end else begin
					want = pending_lengths.pop_front();
					if (result.lcs_length !== want.lcs_length)
						flag_mismatch("lcs_length", result.lcs_length, want.lcs_length);
					if (result.overflow !== want.overflow)
						flag_mismatch("overflow", result.overflow, want.overflow);
				end
			end
			if (start && !busy)
				predict_beat(cmd);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("lcs_length_unit_test: FAIL");
				$finish;
			end
		end
	end

	// hold start high across back-to-back beats; drop it only for a gap
	task automatic send_beat(logic [1:0] kind, logic [lcs_pkg::SymW-1:0] symbol);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= '{kind: kind, symbol: symbol};
		@(posedge clk);
		while (busy) @(posedge clk);
		if (kind != KIND_UNUSED)
			items_sent++;
	endtask

	task automatic test_empty_strings();
		send_beat(lcs_pkg::KIND_FINISH, 8'hFF);
		send_beat(lcs_pkg::KIND_LOAD, 8'h11);
		send_beat(lcs_pkg::KIND_FINISH, 8'h00);
		send_beat(lcs_pkg::KIND_PROCESS, 8'h11);
		send_beat(lcs_pkg::KIND_FINISH, 8'hA5);
	endtask

	task automatic test_symbol_extremes();
		send_beat(lcs_pkg::KIND_LOAD, 8'h00);
		send_beat(lcs_pkg::KIND_LOAD, 8'hFF);
		send_beat(lcs_pkg::KIND_LOAD, 8'h5A);
		send_beat(lcs_pkg::KIND_PROCESS, 8'hFF);
		send_beat(lcs_pkg::KIND_PROCESS, 8'h00);
		send_beat(lcs_pkg::KIND_PROCESS, 8'h5A);
		send_beat(lcs_pkg::KIND_FINISH, 8'h00);
	endtask

	task automatic test_late_y_and_unused_kind();
		send_beat(lcs_pkg::KIND_LOAD, 8'h07);
		send_beat(lcs_pkg::KIND_PROCESS, 8'h07);
		send_beat(KIND_UNUSED, 8'h07);
		send_beat(lcs_pkg::KIND_LOAD, 8'h09);
		send_beat(lcs_pkg::KIND_PROCESS, 8'h09);
		send_beat(lcs_pkg::KIND_FINISH, 8'h09);
	endtask

	// fill y to capacity and match every symbol; optionally push past it
	task automatic test_full_capacity(int extra_loads);
		logic [lcs_pkg::SymW-1:0] ys [CAPACITY];
		for (int j = 0; j < CAPACITY; j++) begin
			ys[j] = 8'($urandom_range(0, 255));
			send_beat(lcs_pkg::KIND_LOAD, ys[j]);
		end
		for (int j = 0; j < extra_loads; j++)
			send_beat(lcs_pkg::KIND_LOAD, 8'($urandom_range(0, 255)));
		for (int j = 0; j < CAPACITY; j++)
			send_beat(lcs_pkg::KIND_PROCESS, ys[j]);
		send_beat(lcs_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// small alphabets around a random base byte give frequent matches
	task automatic test_random_pairs(int budget);
		logic [lcs_pkg::SymW-1:0] base;
		logic [lcs_pkg::SymW-1:0] mask;
		int                       y_n;
		int                       x_n;
		int                       stop_at;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			base = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 3))
				0: mask = 8'h01;
				1: mask = 8'h03;
				2: mask = 8'h07;
				default: mask = 8'hFF;
			endcase
			y_n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70)
				: $urandom_range(0, 12);
			x_n = $urandom_range(0, 16);
			for (int j = 0; j < y_n; j++) begin
				send_beat(lcs_pkg::KIND_LOAD, base ^ (mask & 8'($urandom_range(0, 255))));
				if ($urandom_range(0, 29) == 0)
					send_beat(KIND_UNUSED, 8'($urandom_range(0, 255)));
			end
			for (int j = 0; j < x_n; j++) begin
				send_beat(lcs_pkg::KIND_PROCESS, base ^ (mask & 8'($urandom_range(0, 255))));
				if ($urandom_range(0, 11) == 0)
					send_beat(lcs_pkg::KIND_LOAD, base ^ (mask & 8'($urandom_range(0, 255))));
				if ($urandom_range(0, 19) == 0)
					send_beat(KIND_UNUSED, 8'($urandom_range(0, 255)));
			end
			send_beat(lcs_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		clear_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_strings();
		test_symbol_extremes();
		test_late_y_and_unused_kind();
		gap_pct = 30;
		test_full_capacity(0);
		test_full_capacity($urandom_range(1, 6));
		test_random_pairs(150);
		gap_pct = 0;
		test_random_pairs(100);
		gap_pct = 60;
		test_random_pairs(120);
		gap_pct = 0;
		test_random_pairs(120);

		start <= 1'b0;
		while (pending_lengths.size() != 0) @(posedge clk);
		repeat (2 * CAPACITY) @(posedge clk);

		if (mismatches == 0)
			$display("lcs_length_unit_test: PASS");
		else
			$display("lcs_length_unit_test: FAIL");
		$finish;
	end

endmodule
